// File: src/bip_pkg.sv
// Shared constants and types of the binary image perimeter block.
`default_nettype none
package bip_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 1024;
  localparam int unsigned CfgWidth         = 11;
  localparam int unsigned CountWidth       = 23;
  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // Per-pixel information handed from the scan stage to the accumulator.
  typedef struct packed {
    logic px;         // current pixel
    logic left_set;   // set left neighbor in the same row
    logic above_en;   // row above exists (not the top row)
    logic frame_end;  // last pixel of the frame
  } pix_info_t;

endpackage
`default_nettype wire

// File: src/binary_image_perimeter.sv
// Top level of the binary image perimeter counter.
`default_nettype none
// Counts the 4-connected perimeter of a binary image: pixels arrive in raster
// order, one per request on the slave stream, and every set pixel adds its
// exposed unit edges (edges facing a clear pixel or the image border) to a
// running total. At the last pixel of each frame one request carrying the
// total, saturated to 23 bits, leaves on the master stream and the count
// restarts. Image width and height come from the configuration port (index 0
// and 1); zero acts as one and values above MAX_WIDTH / MAX_HEIGHT act as
// that maximum. Throughput is one pixel per clock unless a frame's last pixel
// waits for an earlier total still held on the master stream: each pixel costs
// a single read-modify-write of the one-bit line buffer memory (read-first, so
// the old pixel above is read in the same cycle the new pixel is written). The
// last pixel passes the accumulator stage register, then the result register
// that drives m_axis_tvalid. Directly after reset the block clears every line
// buffer entry, holding s_axis_tready low meanwhile; configuration writes are taken as usual.
module binary_image_perimeter #(
  parameter int unsigned MAX_WIDTH  = bip_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bip_pkg::MaxHeightDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration writes.
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_addr_i,
  input  wire logic [bip_pkg::CfgWidth-1:0] cfg_wdata_i,
  // Pixel stream.
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // [0] pixel_set, [7:1] zero
  // Result stream.
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [23:0]                       m_axis_tdata    // [22:0] perimeter_count, [23] zero
);
  import bip_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic            accept, advance;
  pix_info_t       info;
  logic            ram_we, ram_wdata, ram_re, ram_rdata;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [CountWidth-1:0] count;

  // Position tracking, config registers and line-buffer addressing.
  bip_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_i       (s_axis_tdata[0]),
    .pix_ready_o (s_axis_tready),
    .advance_i   (advance),
    .accept_o    (accept),
    .info_o      (info),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  // One-row line buffer holding the pixels of the row above.
  bip_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Edge count and result register; stall the pipe only when a finished
  // total would overwrite one still waiting on the master side.
  bip_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .info_i      (info),
    .above_i     (ram_rdata),
    .advance_o   (advance),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_count_o (count)
  );

  assign m_axis_tdata = {1'b0, count};

endmodule
`default_nettype wire

// File: src/bip_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module bip_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and a write to the same entry return the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/bip_scan.sv
// Frame position counters, configuration registers and line-buffer access.
`default_nettype none
module bip_scan #(
  parameter int unsigned MAX_WIDTH  = bip_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bip_pkg::MaxHeightDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_addr_i,
  input  wire logic [bip_pkg::CfgWidth-1:0]  cfg_wdata_i,
  input  wire logic                          pix_valid_i,
  input  wire logic                          pix_i,
  output logic                               pix_ready_o,
  input  wire logic                          advance_i,
  output logic                               accept_o,
  output bip_pkg::pix_info_t                 info_o,
  output logic                               ram_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       ram_waddr_o,
  output logic                               ram_wdata_o,
  output logic                               ram_re_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       ram_raddr_o
);
  import bip_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned MWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned MHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW0 = (MWW > MHW) ? MWW : MHW;
  localparam int unsigned DW  = (DW0 > CfgWidth) ? DW0 : CfgWidth;
  localparam logic [DW-1:0] MaxW    = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] MaxH    = DW'(MAX_HEIGHT);
  localparam logic [AW-1:0] LastAdr = AW'(MAX_WIDTH - 1);

  logic [CfgWidth-1:0] width_q, height_q;
  logic [AW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic                left_q, left_d;
  logic                clr_busy_q;
  logic [AW-1:0]       clr_addr_q;
  logic [DW-1:0]       w_raw, h_raw, w_eff, h_eff, col_inc, row_inc;
  logic                row_end, frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidth'(MaxWidthDefault);
      height_q <= CfgWidth'(MaxHeightDefault);
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_wdata_i;
      end else begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  // Clamp the dimensions into 1..max.
  always_comb begin
    w_raw = DW'(width_q);
    h_raw = DW'(height_q);
    if (w_raw == '0) begin
      w_eff = DW'(1);
    end else if (w_raw > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = DW'(1);
    end else if (h_raw > MaxH) begin
      h_eff = MaxH;
    end else begin
      h_eff = h_raw;
    end
  end

  assign col_inc   = DW'(col_q) + DW'(1);
  assign row_inc   = DW'(row_q) + DW'(1);
  assign row_end   = col_inc >= w_eff;
  assign frame_end = row_end && (row_inc >= h_eff);

  assign pix_ready_o = !clr_busy_q && advance_i;
  assign accept_o    = pix_valid_i && pix_ready_o;

  always_comb begin
    info_o.px        = pix_i;
    info_o.left_set  = left_q;
    info_o.above_en  = (row_q != '0);
    info_o.frame_end = frame_end;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (accept_o) begin
      if (row_end) begin
        col_d  = '0;
        left_d = 1'b0;
        row_d  = frame_end ? '0 : row_inc[RW-1:0];
      end else begin
        col_d  = col_inc[AW-1:0];
        left_d = pix_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
    end
  end

  // Sweep the line buffer to zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == LastAdr) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign ram_we_o    = accept_o || clr_busy_q;
  assign ram_waddr_o = clr_busy_q ? clr_addr_q : col_q;
  assign ram_wdata_o = clr_busy_q ? 1'b0 : pix_i;
  assign ram_re_o    = accept_o;
  assign ram_raddr_o = col_q;

endmodule
`default_nettype wire

// File: src/bip_accum.sv
// Edge accumulator and result register.
`default_nettype none
module bip_accum #(
  parameter int unsigned MAX_WIDTH  = bip_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bip_pkg::MaxHeightDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire bip_pkg::pix_info_t              info_i,
  input  wire logic                            above_i,
  output logic                                 advance_o,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output logic [bip_pkg::CountWidth-1:0]       res_count_o
);
  import bip_pkg::*;

  localparam int unsigned TW0 = $clog2(4 * MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned SW  = (TW0 > CountWidth) ? TW0 : CountWidth;

  logic                  s1_valid_q;
  pix_info_t             s1_q;
  logic [SW-1:0]         total_q, sum;
  logic [2:0]            delta;
  logic                  above;
  logic                  out_valid_q;
  logic [CountWidth-1:0] out_count_q;
  logic                  fire;

  assign above     = above_i && s1_q.above_en;
  assign advance_o = !s1_valid_q || !(s1_q.frame_end && out_valid_q && !res_ready_i);
  assign fire      = s1_valid_q && advance_o;

  always_comb begin
    delta = 3'd0;
    if (s1_q.px) begin
      delta = 3'd4 - {1'b0, s1_q.left_set, 1'b0} - {1'b0, above, 1'b0};
    end
  end

  assign sum = total_q + SW'(delta);

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= info_i;
    end
    if (fire && s1_q.frame_end) begin
      out_count_q <= (sum > SW'(CountMax)) ? CountMax : sum[CountWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        s1_valid_q <= accept_i;
      end
      if (fire) begin
        total_q <= s1_q.frame_end ? '0 : sum;
      end
      if (fire && s1_q.frame_end) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_count_o = out_count_q;

endmodule
`default_nettype wire
